>>> rtl/core/asrf_pkg.sv
// ----------------------------------------------------------------------------
// asrf_pkg
// Shared types, register indexes and reset values for the adaptive sensor
// report state machine.
// ----------------------------------------------------------------------------
package asrf_pkg;

  // Field widths
  localparam int DIST_W = 16;
  localparam int TIME_W = 32;
  localparam int IVAL_W = 16;
  localparam int BAND_W = 16;
  localparam int RUN_W  = 8;
  localparam int MODE_W = 2;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Stream payload widths (padded to whole bytes)
  localparam int S_DATA_W = 48;
  localparam int M_DATA_W = 24;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BOOT_INTERVAL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRACK_INTERVAL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STABLE_INTERVAL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HB_INTERVAL     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STABLE_BAND     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CHANGE_BAND     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SEND_BAND       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_READINGS_NEEDED = 3'd7;

  // Register reset values
  localparam logic [IVAL_W-1:0] RST_BOOT_INTERVAL   = 16'd5000;
  localparam logic [IVAL_W-1:0] RST_TRACK_INTERVAL  = 16'd10000;
  localparam logic [IVAL_W-1:0] RST_STABLE_INTERVAL = 16'd60000;
  localparam logic [TIME_W-1:0] RST_HB_INTERVAL     = 32'd60000;
  localparam logic [BAND_W-1:0] RST_STABLE_BAND     = 16'd2;
  localparam logic [BAND_W-1:0] RST_CHANGE_BAND     = 16'd3;
  localparam logic [BAND_W-1:0] RST_SEND_BAND       = 16'd1;
  localparam logic [RUN_W-1:0]  RST_READINGS_NEEDED = 8'd5;

  localparam logic [RUN_W-1:0] RUN_MAX = '1;

  // Output mode codes
  localparam logic [MODE_W-1:0] MODE_CODE_BOOT     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CODE_STABLE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CODE_TRACKING = 2'd2;

  // Mode state, one-hot
  typedef enum logic [2:0] {
    MODE_BOOT     = 3'b001,
    MODE_STABLE   = 3'b010,
    MODE_TRACKING = 3'b100
  } mode_t;

  // Configuration register file contents
  typedef struct packed {
    logic [IVAL_W-1:0] boot_interval_ms;
    logic [IVAL_W-1:0] tracking_interval_ms;
    logic [IVAL_W-1:0] stable_interval_ms;
    logic [TIME_W-1:0] heartbeat_interval_ms;
    logic [BAND_W-1:0] stable_band_cm;
    logic [BAND_W-1:0] change_band_cm;
    logic [BAND_W-1:0] send_band_cm;
    logic [RUN_W-1:0]  stable_readings_needed;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic              sampled;
    logic              report;
    logic              heartbeat;
    logic [DIST_W-1:0] report_cm;
    logic [MODE_W-1:0] mode;
  } result_t;

  function automatic logic [MODE_W-1:0] mode_code(input mode_t m);
    logic [MODE_W-1:0] code;
    case (m)
      MODE_BOOT:     code = MODE_CODE_BOOT;
      MODE_STABLE:   code = MODE_CODE_STABLE;
      MODE_TRACKING: code = MODE_CODE_TRACKING;
      default:       code = MODE_CODE_STABLE;
    endcase
    return code;
  endfunction

endpackage

>>> rtl/core/asrf_cfg_regs.sv
// ----------------------------------------------------------------------------
// asrf_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module asrf_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [asrf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [asrf_pkg::CFG_DATA_W-1:0]     cfg_data,
  output asrf_pkg::cfg_t                      cfg
);

  // Register writes, truncated to each register's width
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.boot_interval_ms       <= asrf_pkg::RST_BOOT_INTERVAL;
      cfg.tracking_interval_ms   <= asrf_pkg::RST_TRACK_INTERVAL;
      cfg.stable_interval_ms     <= asrf_pkg::RST_STABLE_INTERVAL;
      cfg.heartbeat_interval_ms  <= asrf_pkg::RST_HB_INTERVAL;
      cfg.stable_band_cm         <= asrf_pkg::RST_STABLE_BAND;
      cfg.change_band_cm         <= asrf_pkg::RST_CHANGE_BAND;
      cfg.send_band_cm           <= asrf_pkg::RST_SEND_BAND;
      cfg.stable_readings_needed <= asrf_pkg::RST_READINGS_NEEDED;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        asrf_pkg::REG_BOOT_INTERVAL:
          cfg.boot_interval_ms <= cfg_data[asrf_pkg::IVAL_W-1:0];
        asrf_pkg::REG_TRACK_INTERVAL:
          cfg.tracking_interval_ms <= cfg_data[asrf_pkg::IVAL_W-1:0];
        asrf_pkg::REG_STABLE_INTERVAL:
          cfg.stable_interval_ms <= cfg_data[asrf_pkg::IVAL_W-1:0];
        asrf_pkg::REG_HB_INTERVAL:
          cfg.heartbeat_interval_ms <= cfg_data[asrf_pkg::TIME_W-1:0];
        asrf_pkg::REG_STABLE_BAND:
          cfg.stable_band_cm <= cfg_data[asrf_pkg::BAND_W-1:0];
        asrf_pkg::REG_CHANGE_BAND:
          cfg.change_band_cm <= cfg_data[asrf_pkg::BAND_W-1:0];
        asrf_pkg::REG_SEND_BAND:
          cfg.send_band_cm <= cfg_data[asrf_pkg::BAND_W-1:0];
        asrf_pkg::REG_READINGS_NEEDED:
          cfg.stable_readings_needed <= cfg_data[asrf_pkg::RUN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/core/asrf_core.sv
// ----------------------------------------------------------------------------
// asrf_core
// Mode state machine and tracking state; evaluates one registered sample
// per enabled cycle and produces the result for the output register.
// ----------------------------------------------------------------------------
module asrf_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              step,
  input  logic [asrf_pkg::DIST_W-1:0]       distance_cm,
  input  logic [asrf_pkg::TIME_W-1:0]       time_ms,
  input  asrf_pkg::cfg_t                    cfg,
  output asrf_pkg::result_t                 result
);

  asrf_pkg::mode_t                mode, mode_next;
  logic [asrf_pkg::DIST_W-1:0]    baseline_cm, baseline_cm_next;
  logic [asrf_pkg::RUN_W-1:0]     stable_run, stable_run_next;
  logic [asrf_pkg::TIME_W-1:0]    last_measure, last_measure_next;
  logic [asrf_pkg::TIME_W-1:0]    last_hb, last_hb_next;
  logic                           baseline_valid, baseline_valid_next;

  logic [asrf_pkg::IVAL_W-1:0]    interval;
  logic                           due;
  logic                           hb_due;
  logic [asrf_pkg::DIST_W-1:0]    delta;
  logic                           is_stable;
  logic                           run_done;
  logic [asrf_pkg::RUN_W-1:0]     run_inc;

  // Interval for the current mode; unused codes fall back to stable
  always_comb begin
    case (mode)
      asrf_pkg::MODE_BOOT:     interval = cfg.boot_interval_ms;
      asrf_pkg::MODE_TRACKING: interval = cfg.tracking_interval_ms;
      default:                 interval = cfg.stable_interval_ms;
    endcase
  end

  // Wrapping time compares and distance deviation
  assign due    = (time_ms - last_measure) >= {16'd0, interval};
  assign hb_due = (time_ms - last_hb) >= cfg.heartbeat_interval_ms;
  assign delta  = (distance_cm >= baseline_cm) ? (distance_cm - baseline_cm)
                                               : (baseline_cm - distance_cm);
  assign is_stable = delta <= cfg.stable_band_cm;
  assign run_inc   = (stable_run == asrf_pkg::RUN_MAX) ? stable_run
                                                       : stable_run + 1'b1;
  assign run_done  = run_inc >= cfg.stable_readings_needed;

  // Next state and result
  always_comb begin
    mode_next           = mode;
    baseline_cm_next    = baseline_cm;
    stable_run_next     = stable_run;
    last_measure_next   = last_measure;
    last_hb_next        = last_hb;
    baseline_valid_next = baseline_valid;
    result.sampled      = 1'b0;
    result.report       = 1'b0;
    result.heartbeat    = 1'b0;
    result.report_cm    = '0;

    if (due) begin
      result.sampled    = 1'b1;
      last_measure_next = time_ms;
      case (mode)
        asrf_pkg::MODE_BOOT: begin
          if (!baseline_valid) begin
            baseline_cm_next    = distance_cm;
            stable_run_next     = 8'd1;
            baseline_valid_next = 1'b1;
            last_hb_next        = time_ms;
            result.report       = 1'b1;
            result.report_cm    = distance_cm;
          end else if (is_stable) begin
            stable_run_next = run_inc;
            if (run_done) begin
              mode_next        = asrf_pkg::MODE_STABLE;
              baseline_cm_next = distance_cm;
              stable_run_next  = '0;
              last_hb_next     = time_ms;
              result.report    = 1'b1;
              result.report_cm = distance_cm;
            end
          end else begin
            baseline_cm_next = distance_cm;
            stable_run_next  = 8'd1;
            if (delta > cfg.send_band_cm) begin
              result.report    = 1'b1;
              result.report_cm = distance_cm;
            end
          end
        end
        asrf_pkg::MODE_STABLE: begin
          if (delta > cfg.change_band_cm) begin
            // Large change: track it and measure again at once
            mode_next         = asrf_pkg::MODE_TRACKING;
            baseline_cm_next  = distance_cm;
            stable_run_next   = '0;
            last_measure_next = time_ms - {16'd0, cfg.tracking_interval_ms};
            last_hb_next      = time_ms;
            result.report     = 1'b1;
            result.report_cm  = distance_cm;
          end else if (hb_due) begin
            last_hb_next     = time_ms;
            result.report    = 1'b1;
            result.heartbeat = 1'b1;
          end
        end
        asrf_pkg::MODE_TRACKING: begin
          if (is_stable) begin
            stable_run_next = run_inc;
            if (run_done) begin
              mode_next        = asrf_pkg::MODE_STABLE;
              baseline_cm_next = distance_cm;
              stable_run_next  = '0;
              last_hb_next     = time_ms;
              result.report    = 1'b1;
              result.report_cm = distance_cm;
            end
          end else begin
            stable_run_next = '0;
            if (delta > cfg.send_band_cm) begin
              baseline_cm_next = distance_cm;
              result.report    = 1'b1;
              result.report_cm = distance_cm;
            end
          end
        end
        default: ;
      endcase
    end
    result.mode = asrf_pkg::mode_code(mode_next);
  end

  // State registers, advanced once per evaluated transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= asrf_pkg::MODE_BOOT;
      baseline_cm    <= '0;
      stable_run     <= '0;
      last_measure   <= '0;
      last_hb        <= '0;
      baseline_valid <= 1'b0;
    end else if (step) begin
      mode           <= mode_next;
      baseline_cm    <= baseline_cm_next;
      stable_run     <= stable_run_next;
      last_measure   <= last_measure_next;
      last_hb        <= last_hb_next;
      baseline_valid <= baseline_valid_next;
    end
  end

endmodule

>>> rtl/core/adaptive_sensor_report_fsm_unit.sv
// ----------------------------------------------------------------------------
// adaptive_sensor_report_fsm_unit
// Decides per distance sample whether it is measured and whether a report
// or heartbeat goes out, keeping boot, stable and tracking modes.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one sample per transaction: tdata = {time_ms, distance_cm}.
//   m_* returns one result per sample: tdata = {mode, report_cm, report,
//   sampled}, tuser = heartbeat.
//   The cfg_* write port loads the eight registers by index; write only when
//   no sample is in flight.
// Pipeline and throughput:
//   A sample is captured in an input register, evaluated by the mode logic
//   and lands in the output register, which raises m_tvalid. One sample per
//   cycle is sustained while m_tready stays high; the limit is the state
//   update of the mode machine.
// Reset:
//   rst (synchronous) empties both registers, restores the register reset
//   values and puts the machine in boot mode without a baseline.
// Stall:
//   With m_tready low the result holds; one more sample is still taken into
//   the input register, then s_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module adaptive_sensor_report_fsm_unit (
  input  logic                               clk,
  input  logic                               rst,
  // Configuration write port
  input  logic                               cfg_wr_en,
  input  logic [asrf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [asrf_pkg::CFG_DATA_W-1:0]    cfg_data,
  // Sample stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [asrf_pkg::S_DATA_W-1:0]      s_tdata,   // [15:0] distance_cm, [47:16] time_ms
  // Result stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [asrf_pkg::M_DATA_W-1:0]      m_tdata,   // [0] sampled, [1] report,
                                                        // [17:2] report_cm, [19:18] mode
  output logic                               m_tuser    // [0] heartbeat
);

  asrf_pkg::cfg_t                 cfg;
  asrf_pkg::result_t              result;
  asrf_pkg::result_t              out_res;
  logic                           in_valid;
  logic [asrf_pkg::DIST_W-1:0]    in_dist;
  logic [asrf_pkg::TIME_W-1:0]    in_time;
  logic                           out_adv;
  logic                           step;

  // Handshake control
  assign out_adv  = !m_tvalid || m_tready;
  assign step     = in_valid && out_adv;
  assign s_tready = !in_valid || out_adv;

  asrf_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_dist <= s_tdata[asrf_pkg::DIST_W-1:0];
      in_time <= s_tdata[asrf_pkg::DIST_W +: asrf_pkg::TIME_W];
    end
  end

  asrf_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .distance_cm (in_dist),
    .time_ms     (in_time),
    .cfg         (cfg),
    .result      (result)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_adv) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= result;
    end
  end

  assign m_tdata = {4'd0, out_res.mode, out_res.report_cm, out_res.report, out_res.sampled};
  assign m_tuser = out_res.heartbeat;

endmodule

>>> rtl/core/asrf_checker.sv
// ----------------------------------------------------------------------------
// asrf_checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module asrf_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [asrf_pkg::M_DATA_W-1:0]   m_tdata,
  input logic                            m_tuser
);

  // A stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // A report needs an evaluated sample
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1] |-> m_tdata[0])
    else $error("report without sampled");

  // A heartbeat is a report and carries no distance
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[1] && (m_tdata[17:2] == '0))
    else $error("bad heartbeat result");

  // No report means no distance
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[1] |-> (m_tdata[17:2] == '0) && !m_tuser)
    else $error("distance without report");

  // Mode code is never the unused value
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[19:18] != 2'd3))
    else $error("unused mode code");

endmodule

bind adaptive_sensor_report_fsm_unit asrf_checker u_asrf_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
